// ----- sv/riff_wave_pcm_stream_decoder_top_defines.svh -----
// Assertion macros shared by the WAV decoder RTL.
`ifndef RIFF_WAVE_PCM_STREAM_DECODER_TOP_DEFINES_SVH
`define RIFF_WAVE_PCM_STREAM_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define RWD_ASSERT_IMP(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("rwd assertion failed");

// Next-cycle implication, sampled on i_clk, off during reset.
`define RWD_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("rwd assertion failed");

`endif

// ----- sv/rwd_pkg.sv -----
// Shared types, codes and helpers for the WAV PCM stream decoder.
`timescale 1ns / 1ps

package rwd_pkg;

    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_ACCEPT = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;

    localparam logic [2:0] ERR_NONE        = 3'd0;
    localparam logic [2:0] ERR_BAD_TAG     = 3'd1;
    localparam logic [2:0] ERR_SHORT_FMT   = 3'd2;
    localparam logic [2:0] ERR_DATA_EARLY  = 3'd3;
    localparam logic [2:0] ERR_NO_DATA     = 3'd4;
    localparam logic [2:0] ERR_UNSUPPORTED = 3'd5;

    localparam logic [31:0] TAG_RIFF = 32'h52494646;
    localparam logic [31:0] TAG_WAVE = 32'h57415645;
    localparam logic [31:0] TAG_FMT  = 32'h666D7420;
    localparam logic [31:0] TAG_DATA = 32'h64617461;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [6:0] {
        PH_HEADER = 7'b0000001,
        PH_CHUNK  = 7'b0000010,
        PH_FMT    = 7'b0000100,
        PH_SKIP   = 7'b0001000,
        PH_PAD    = 7'b0010000,
        PH_DATA   = 7'b0100000,
        PH_IDLE   = 7'b1000000
    } t_phase;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_stream;
    } t_in;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  error_code;
        logic [31:0] sample_value;
        logic [15:0] channel_index;
        logic        last_in_frame;
        logic [31:0] format_sample_rate;
        logic [15:0] format_channels;
        logic [5:0]  format_bits;
        logic [31:0] data_length;
    } t_out;

    // Classified request from the parser; sample still raw.
    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  error_code;
        logic [31:0] raw;
        logic [2:0]  bps;
        logic [15:0] chan;
        logic        last;
        logic [31:0] rate;
        logic [15:0] chans;
        logic [5:0]  bits;
        logic [31:0] length;
    } t_rec;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    // Left-justify a raw little-endian sample to Q1.31.
    function automatic logic [31:0] to_q31(input logic [31:0] raw, input logic [2:0] bps);
        logic [31:0] v;
        case (bps)
            3'd1: v = {raw[7:0] ^ 8'h80, 24'h0};
            3'd2: v = {raw[15:0], 16'h0};
            3'd3: v = {raw[23:0], 8'h0};
            default: v = raw;
        endcase
        return v;
    endfunction

endpackage

// ----- sv/rwd_front.sv -----
// Front end: byte parser that classifies each request and emits result records.
`timescale 1ns / 1ps

module rwd_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  rwd_pkg::t_in    i_data,
    output logic            o_push,
    output rwd_pkg::t_rec   o_rec,
    output logic            o_at_header
);

    rwd_pkg::t_phase r_phase, n_phase;
    logic [31:0] r_cnt, n_cnt;
    logic [31:0] r_tag, n_tag;
    logic [31:0] r_len, n_len;
    logic        r_saw, n_saw;
    logic [15:0] r_fmt, n_fmt;
    logic [15:0] r_ch, n_ch;
    logic [31:0] r_rate, n_rate;
    logic [15:0] r_bits, n_bits;
    logic [31:0] r_left, n_left;
    logic [17:0] r_frame, n_frame;
    logic [31:0] r_asm, n_asm;
    logic [1:0]  r_sbi, n_sbi;
    logic [15:0] r_chc, n_chc;

    logic [7:0]  b;
    logic [31:0] b_sh;
    logic [31:0] cnt_inc;
    logic [2:0]  bps;
    logic        bits_ok;

    assign b       = i_data.in_byte;
    assign b_sh    = {24'h0, b} << {r_cnt[1:0], 3'b000};
    assign cnt_inc = r_cnt + 32'd1;
    assign bps     = r_bits[5:3];
    assign bits_ok = (r_bits == 16'd8) || (r_bits == 16'd16) ||
                     (r_bits == 16'd24) || (r_bits == 16'd32);
    assign o_at_header = (r_phase == rwd_pkg::PH_HEADER);

    always_comb begin
        logic [31:0] len_acc;
        logic [31:0] ashift;
        n_phase = r_phase; n_cnt = r_cnt; n_tag = r_tag; n_len = r_len;
        n_saw = r_saw; n_fmt = r_fmt; n_ch = r_ch; n_rate = r_rate;
        n_bits = r_bits; n_left = r_left; n_frame = r_frame; n_asm = r_asm;
        n_sbi = r_sbi; n_chc = r_chc;
        o_push = 1'b0;
        o_rec  = '0;
        len_acc = 32'h0;
        ashift  = 32'h0;
        if (i_accept) begin
            if (i_data.end_of_stream) begin
                case (r_phase)
                    rwd_pkg::PH_HEADER: begin
                        o_push = 1'b1; o_rec.error_code = rwd_pkg::ERR_BAD_TAG;
                    end
                    rwd_pkg::PH_CHUNK, rwd_pkg::PH_SKIP, rwd_pkg::PH_PAD: begin
                        o_push = 1'b1; o_rec.error_code = rwd_pkg::ERR_NO_DATA;
                    end
                    rwd_pkg::PH_FMT: begin
                        o_push = 1'b1;
                        o_rec.error_code = (r_cnt < 32'd16) ? rwd_pkg::ERR_SHORT_FMT
                                                            : rwd_pkg::ERR_NO_DATA;
                    end
                    default: o_push = 1'b0;
                endcase
                o_rec.kind = rwd_pkg::KIND_REJECT;
                n_phase = rwd_pkg::PH_HEADER; n_cnt = '0; n_tag = '0; n_len = '0;
                n_saw = 1'b0; n_fmt = '0; n_ch = '0; n_rate = '0; n_bits = '0;
                n_left = '0; n_frame = '0; n_asm = '0; n_sbi = '0; n_chc = '0;
            end else begin
                o_rec.kind = rwd_pkg::KIND_REJECT;
                case (r_phase)
                    rwd_pkg::PH_HEADER: begin
                        n_tag = {r_tag[23:0], b};
                        n_cnt = cnt_inc;
                        if ((r_cnt == 32'd3 && n_tag != rwd_pkg::TAG_RIFF) ||
                            (r_cnt == 32'd11 && n_tag != rwd_pkg::TAG_WAVE)) begin
                            o_push = 1'b1;
                            o_rec.error_code = rwd_pkg::ERR_BAD_TAG;
                            n_phase = rwd_pkg::PH_IDLE;
                        end else if (r_cnt == 32'd11) begin
                            n_phase = rwd_pkg::PH_CHUNK;
                            n_cnt = '0;
                        end
                    end
                    rwd_pkg::PH_CHUNK: begin
                        if (r_cnt < 32'd4) begin
                            n_tag = {r_tag[23:0], b};
                        end else begin
                            len_acc = (r_cnt == 32'd4) ? 32'h0 : r_len;
                            n_len = len_acc | b_sh;
                        end
                        n_cnt = cnt_inc;
                        if (r_cnt >= 32'd7) begin
                            n_cnt = '0;
                            if (r_tag == rwd_pkg::TAG_FMT) begin
                                if (n_len < 32'd16) begin
                                    o_push = 1'b1;
                                    o_rec.error_code = rwd_pkg::ERR_SHORT_FMT;
                                    n_phase = rwd_pkg::PH_IDLE;
                                end else begin
                                    n_fmt = '0; n_ch = '0; n_rate = '0; n_bits = '0;
                                    n_phase = rwd_pkg::PH_FMT;
                                end
                            end else if (r_tag == rwd_pkg::TAG_DATA) begin
                                o_push = 1'b1;
                                n_phase = rwd_pkg::PH_IDLE;
                                if (!r_saw) begin
                                    o_rec.error_code = rwd_pkg::ERR_DATA_EARLY;
                                end else if (n_len == 32'h0) begin
                                    o_rec.error_code = rwd_pkg::ERR_NO_DATA;
                                end else if (r_fmt != 16'd1 || r_ch == 16'h0 ||
                                             r_rate == 32'h0 || !bits_ok) begin
                                    o_rec.error_code = rwd_pkg::ERR_UNSUPPORTED;
                                end else begin
                                    o_rec.kind  = rwd_pkg::KIND_ACCEPT;
                                    o_rec.rate  = r_rate;
                                    o_rec.chans = r_ch;
                                    o_rec.bits  = r_bits[5:0];
                                    o_rec.length = n_len;
                                    n_left = n_len;
                                    case (bps)
                                        3'd1: n_frame = {2'b00, r_ch};
                                        3'd2: n_frame = {1'b0, r_ch, 1'b0};
                                        3'd3: n_frame = {2'b00, r_ch} + {1'b0, r_ch, 1'b0};
                                        default: n_frame = {r_ch, 2'b00};
                                    endcase
                                    n_asm = '0; n_sbi = '0; n_chc = '0;
                                    n_phase = rwd_pkg::PH_DATA;
                                end
                            end else begin
                                n_phase = (n_len == 32'h0) ? rwd_pkg::PH_CHUNK
                                                           : rwd_pkg::PH_SKIP;
                            end
                        end
                    end
                    rwd_pkg::PH_FMT: begin
                        if (r_cnt < 32'd2)
                            n_fmt = r_fmt | b_sh[15:0];
                        else if (r_cnt < 32'd4)
                            n_ch = r_ch | b_sh[31:16];
                        else if (r_cnt < 32'd8)
                            n_rate = r_rate | b_sh;
                        else if (r_cnt == 32'd14 || r_cnt == 32'd15)
                            n_bits = r_bits | b_sh[31:16] | b_sh[15:0];
                        if (r_cnt == 32'd15)
                            n_saw = 1'b1;
                        n_cnt = cnt_inc;
                        if (cnt_inc == r_len) begin
                            n_phase = r_len[0] ? rwd_pkg::PH_PAD : rwd_pkg::PH_CHUNK;
                            n_cnt = '0;
                        end
                    end
                    rwd_pkg::PH_SKIP: begin
                        n_cnt = cnt_inc;
                        if (cnt_inc == r_len) begin
                            n_phase = r_len[0] ? rwd_pkg::PH_PAD : rwd_pkg::PH_CHUNK;
                            n_cnt = '0;
                        end
                    end
                    rwd_pkg::PH_PAD: begin
                        n_phase = rwd_pkg::PH_CHUNK;
                        n_cnt = '0;
                    end
                    rwd_pkg::PH_DATA: begin
                        if (r_chc == 16'h0 && r_sbi == 2'd0 &&
                            r_left < {14'h0, r_frame}) begin
                            n_phase = rwd_pkg::PH_IDLE;
                        end else begin
                            n_left = r_left - 32'd1;
                            ashift = {24'h0, b} << {r_sbi, 3'b000};
                            n_asm = ((r_sbi == 2'd0) ? 32'h0 : r_asm) | ashift;
                            if ({1'b0, r_sbi} + 3'd1 < bps) begin
                                n_sbi = r_sbi + 2'd1;
                            end else begin
                                n_sbi = '0;
                                o_push = 1'b1;
                                o_rec.kind = rwd_pkg::KIND_SAMPLE;
                                o_rec.raw  = n_asm;
                                o_rec.bps  = bps;
                                o_rec.chan = r_chc;
                                if ({1'b0, r_chc} + 17'd1 >= {1'b0, r_ch}) begin
                                    o_rec.last = 1'b1;
                                    n_chc = '0;
                                end else begin
                                    n_chc = r_chc + 16'd1;
                                end
                            end
                        end
                    end
                    default: o_push = 1'b0;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= rwd_pkg::PH_HEADER;
            r_cnt <= '0; r_tag <= '0; r_len <= '0; r_saw <= 1'b0;
            r_fmt <= '0; r_ch <= '0; r_rate <= '0; r_bits <= '0;
            r_left <= '0; r_frame <= '0; r_asm <= '0; r_sbi <= '0; r_chc <= '0;
        end else begin
            r_phase <= n_phase;
            r_cnt <= n_cnt; r_tag <= n_tag; r_len <= n_len; r_saw <= n_saw;
            r_fmt <= n_fmt; r_ch <= n_ch; r_rate <= n_rate; r_bits <= n_bits;
            r_left <= n_left; r_frame <= n_frame; r_asm <= n_asm;
            r_sbi <= n_sbi; r_chc <= n_chc;
        end
    end

endmodule

// ----- sv/rwd_queue.sv -----
// Short request queue between parser and output stage.
`timescale 1ns / 1ps

module rwd_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  rwd_pkg::t_rec    i_rec,
    input  logic             i_pop,
    output rwd_pkg::t_rec    o_head,
    output rwd_pkg::t_qstat  o_stat
);

    localparam int PW = $clog2(rwd_pkg::QUEUE_DEPTH);

    rwd_pkg::t_rec r_mem [rwd_pkg::QUEUE_DEPTH];
    logic [PW-1:0] r_wp, n_wp;
    logic [PW-1:0] r_rp, n_rp;
    logic [PW:0]   r_cnt, n_cnt;
    logic          do_push, do_pop;

    assign o_stat.full  = (r_cnt == (PW+1)'(rwd_pkg::QUEUE_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign do_push = i_push && !o_stat.full;
    assign do_pop  = i_pop && !o_stat.empty;
    assign o_head  = r_mem[r_rp];

    always_comb begin
        n_wp  = do_push ? r_wp + PW'(1) : r_wp;
        n_rp  = do_pop  ? r_rp + PW'(1) : r_rp;
        n_cnt = r_cnt + (PW+1)'(do_push) - (PW+1)'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            r_wp <= n_wp; r_rp <= n_rp; r_cnt <= n_cnt;
        end
    end

endmodule

// ----- sv/rwd_back.sv -----
// Back end: converts queued records and holds them in the output register.
`timescale 1ns / 1ps

module rwd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rwd_pkg::t_rec    i_head,
    input  rwd_pkg::t_qstat  i_stat,
    output logic             o_pop,
    input  logic             i_out_stall,
    output logic             o_out_valid,
    output rwd_pkg::t_out    o_out_data
);

    logic          r_valid;
    rwd_pkg::t_out r_out, n_out;

    assign o_pop = !i_stat.empty && (!r_valid || !i_out_stall);
    assign o_out_valid = r_valid;
    assign o_out_data  = r_out;

    always_comb begin
        n_out = '0;
        n_out.kind       = i_head.kind;
        n_out.error_code = i_head.error_code;
        case (i_head.kind)
            rwd_pkg::KIND_SAMPLE: begin
                n_out.sample_value  = rwd_pkg::to_q31(i_head.raw, i_head.bps);
                n_out.channel_index = i_head.chan;
                n_out.last_in_frame = i_head.last;
            end
            rwd_pkg::KIND_ACCEPT: begin
                n_out.format_sample_rate = i_head.rate;
                n_out.format_channels    = i_head.chans;
                n_out.format_bits        = i_head.bits;
                n_out.data_length        = i_head.length;
            end
            default: n_out.sample_value = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

endmodule

// ----- sv/riff_wave_pcm_stream_decoder_top.sv -----
// Top level of the RIFF/WAVE PCM byte-stream decoder.
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data): one request per cycle
//   while o_in_stall is low, either a file byte or an end-of-stream mark. End
//   of stream returns the parser to the RIFF header state and may raise a reject.
//   Output channel (o_out_valid / i_out_stall / o_out_data): at most one result
//   per input request: a Q1.31 sample, a format accept, or a reject with code.
// Throughput: one byte per cycle, sustained, while the output keeps up.
// A result is registered first in the queue, which the parser writes when its
//   byte is accepted, then in the output register, which the output stage loads
//   when it pops the queue; a stalled output holds the pop back.
// The parser only stalls when the two-entry result queue is full, so the
//   queue depth sets how long the input runs on while the receiver stalls.
// Output register holds its result stable while i_out_stall is high.
// Reset (i_rst_n low, synchronous) empties queue and output, and puts the
//   parser back to expecting the RIFF tag with all fmt fields cleared.
`timescale 1ns / 1ps
`include "riff_wave_pcm_stream_decoder_top_defines.svh"

module riff_wave_pcm_stream_decoder_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  rwd_pkg::t_in   i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output rwd_pkg::t_out  o_out_data
);

    logic             in_acc;
    logic             push;
    logic             pop;
    logic             at_header;
    rwd_pkg::t_rec    rec;
    rwd_pkg::t_rec    head;
    rwd_pkg::t_qstat  qstat;

    // Stall only on a full queue: the parser may emit one record per byte.
    assign o_in_stall = qstat.full;
    assign in_acc     = i_in_valid && !o_in_stall;

    rwd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (in_acc),
        .i_data     (i_in_data),
        .o_push     (push),
        .o_rec      (rec),
        .o_at_header(at_header)
    );

    rwd_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_rec  (rec),
        .i_pop  (pop),
        .o_head (head),
        .o_stat (qstat)
    );

    rwd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .i_stat     (qstat),
        .o_pop      (pop),
        .i_out_stall(i_out_stall),
        .o_out_valid(o_out_valid),
        .o_out_data (o_out_data)
    );

    // End of stream always leaves the parser back at the header.
    `RWD_ASSERT_NEXT(a_eos_to_header, in_acc && i_in_data.end_of_stream, at_header)
    // Parser never writes a record the queue cannot hold.
    `RWD_ASSERT_IMP(a_no_overflow, push, !qstat.full)
    // A record is only popped when one is present and then shows up at the port.
    `RWD_ASSERT_NEXT(a_pop_shows, pop, o_out_valid)

endmodule
